// ===== rtl/core/krt_pkg.sv =====
// Key rollover tracker package: operation, item, result, chain carry and close types.
// No dependencies; imported by krt_cell, key_rollover_tracker and the bench.
`default_nettype none
package krt_pkg;

  localparam int unsigned KEY_W = 31;

  typedef enum logic [1:0] {
    OP_KEY_DOWN = 2'd0,
    OP_KEY_UP   = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_QUERY    = 2'd3
  } krt_op_e;

  typedef struct packed {
    krt_op_e          operation;
    logic [KEY_W-1:0] key_code;
  } krt_item_t;

  typedef struct packed {
    logic key_held;
    logic key_pressed;
    logic any_held;
    logic any_pressed;
  } krt_result_t;

  // Handed from cell to cell as the scan token moves down the row.
  typedef struct packed {
    logic found;       // key already sat in a valid held slot
    logic placed;      // key written into a free held slot
    logic held_hit;
    logic press_hit;
    logic any_held;
    logic any_pressed;
  } krt_carry_t;

  // Broadcast in the cycle after the scan reaches cell 0.
  typedef struct packed {
    logic fin;
    logic revert;      // drop a tentative held entry, key was already held
  } krt_close_t;

endpackage
`default_nettype wire

// ===== rtl/core/krt_cell.sv =====
// One slot of the key rollover tracker: a held entry and a press entry.
// Depends on krt_pkg.
`default_nettype none
module krt_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           act_i,
  input  krt_pkg::krt_op_e               op_i,
  input  logic [krt_pkg::KEY_W-1:0]      key_i,
  input  krt_pkg::krt_carry_t            carry_i,
  input  logic                           prev_pvalid_i,
  input  krt_pkg::krt_close_t            close_i,
  output logic                           act_o,
  output krt_pkg::krt_carry_t            carry_o,
  output logic                           pvalid_o
);
  import krt_pkg::*;

  logic             hvalid_q, hvalid_d;
  logic             tent_q, tent_d;
  logic             pvalid_q, pvalid_d;
  logic [KEY_W-1:0] hkey_q;
  logic [KEY_W-1:0] pkey_q;
  logic             act_q;
  krt_carry_t       carry_q, carry_d;

  logic hmatch, hins, hdrop, hnew;
  logic pmatch, pappend, pnew;

  always_comb begin
    hmatch  = hvalid_q && (hkey_q == key_i);
    hins    = (op_i == OP_KEY_DOWN) && !hvalid_q && !carry_i.found && !carry_i.placed;
    hdrop   = (op_i == OP_KEY_UP) && hmatch;
    hnew    = hins || (hvalid_q && !hdrop);
    pmatch  = pvalid_q && (pkey_q == key_i);
    pappend = (op_i == OP_KEY_DOWN) && !pvalid_q && prev_pvalid_i;
    pnew    = (op_i != OP_CLEAR) && (pappend || pvalid_q);

    carry_d.found       = carry_i.found || hmatch;
    carry_d.placed      = carry_i.placed || hins;
    carry_d.held_hit    = carry_i.held_hit || (hnew && (hins || hmatch));
    carry_d.press_hit   = carry_i.press_hit || (pnew && (pappend || pmatch));
    carry_d.any_held    = carry_i.any_held || hnew;
    carry_d.any_pressed = carry_i.any_pressed || pnew;

    hvalid_d = hvalid_q;
    tent_d   = tent_q;
    pvalid_d = pvalid_q;
    if (act_i) begin
      hvalid_d = hnew;
      tent_d   = hins;
      pvalid_d = pnew;
    end else if (close_i.fin) begin
      tent_d = 1'b0;
      if (close_i.revert && tent_q) begin
        hvalid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q <= 1'b0;
      tent_q   <= 1'b0;
      pvalid_q <= 1'b0;
      act_q    <= 1'b0;
      carry_q  <= '0;
    end else begin
      hvalid_q <= hvalid_d;
      tent_q   <= tent_d;
      pvalid_q <= pvalid_d;
      act_q    <= act_i;
      if (act_i) begin
        carry_q <= carry_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_i && hins) begin
      hkey_q <= key_i;
    end
    if (act_i && pappend) begin
      pkey_q <= key_i;
    end
  end

  assign act_o    = act_q;
  assign carry_o  = carry_q;
  assign pvalid_o = pvalid_q;

endmodule
`default_nettype wire

// ===== rtl/core/key_rollover_tracker.sv =====
// Key rollover tracker top level: command latch, row of slot cells, result.
// Depends on krt_pkg and krt_cell.
//
// From acceptance, an item goes through the command latch, then a scan token
// walks the row of cells from the top slot down to slot 0, one cell a
// cycle, and a closing step then settles a tentative held entry and
// shows the result on done_o. busy is low during that closing step, so a
// new item may be accepted there; before that step no new item is taken.
// The result is valid for the single cycle in which done_o is high;
// the receiver cannot stall it.
`default_nettype none
module key_rollover_tracker #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  krt_pkg::krt_item_t   item_i,
  output logic                 done_o,
  output krt_pkg::krt_result_t result_o
);
  import krt_pkg::*;

  logic       go_q;
  krt_item_t  cmd_q;
  logic       accept;
  krt_close_t close;

  logic       [SLOTS-1:0] act_in;
  logic       [SLOTS-1:0] act_out;
  logic       [SLOTS-1:0] pvalid;
  logic       [SLOTS-1:0] prev_pvalid;
  krt_carry_t [SLOTS-1:0] carry_in;
  krt_carry_t [SLOTS-1:0] carry_out;

  assign accept = start && !busy;
  assign busy   = go_q || (|(act_out >> 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q <= 1'b0;
    end else begin
      go_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= item_i;
    end
  end

  assign close.fin    = act_out[0];
  assign close.revert = act_out[0] && carry_out[0].found;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_head
      assign act_in[i]   = go_q;
      assign carry_in[i] = '0;
    end else begin : g_body
      assign act_in[i]   = act_out[i+1];
      assign carry_in[i] = carry_out[i+1];
    end
    if (i == 0) begin : g_base
      assign prev_pvalid[i] = 1'b1;
    end else begin : g_link
      assign prev_pvalid[i] = pvalid[i-1];
    end

    krt_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .act_i         (act_in[i]),
      .op_i          (cmd_q.operation),
      .key_i         (cmd_q.key_code),
      .carry_i       (carry_in[i]),
      .prev_pvalid_i (prev_pvalid[i]),
      .close_i       (close),
      .act_o         (act_out[i]),
      .carry_o       (carry_out[i]),
      .pvalid_o      (pvalid[i])
    );
  end

  assign done_o               = act_out[0];
  assign result_o.key_held    = carry_out[0].held_hit;
  assign result_o.key_pressed = carry_out[0].press_hit;
  assign result_o.any_held    = carry_out[0].any_held;
  assign result_o.any_pressed = carry_out[0].any_pressed;

  a_token_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({go_q, act_out}))
    else $error("more than one scan token in the cell row");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && go_q)
    else $error("accepted item did not start a scan");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while scan still running");

  a_up_not_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (cmd_q.operation == OP_KEY_UP) |-> !result_o.key_held)
    else $error("key still held after key-up");

  a_clear_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (cmd_q.operation == OP_CLEAR) |-> !result_o.any_pressed
      && !result_o.key_pressed)
    else $error("press list not empty after clear");

endmodule
`default_nettype wire

// ===== bench/key_rollover_tracker_tb.sv =====
// Self-checking bench for key_rollover_tracker: directed and random key events,
// each result checked against a behavioural model of the held and press tables.
// Depends on krt_pkg and the key_rollover_tracker RTL.
module key_rollover_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import krt_pkg::*;

  localparam int unsigned SLOTS = 8;
  localparam int unsigned ITEM_LAT = SLOTS + 1;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam logic [KEY_W-1:0] KEY_TOP = '1;
  localparam logic [KEY_W-1:0] KEY_ZERO = '0;

  class rollover_scoreboard;
    logic [KEY_W-1:0] held_code [SLOTS];
    bit               held_on   [SLOTS];
    logic [KEY_W-1:0] press_code[SLOTS];
    bit               press_on  [SLOTS];
    krt_result_t      flags_due [$];
    int unsigned      mismatches;

    function void note_item(krt_item_t it);
      int free_held;
      bit seen;
      krt_result_t flags;
      free_held = -1;
      seen = 1'b0;
      case (it.operation)
        OP_KEY_DOWN: begin
          // held: highest free slot unless already there; press: lowest free slot
          for (int i = 0; i < SLOTS; i++) begin
            if (held_on[i] && held_code[i] == it.key_code) seen = 1'b1;
            if (!held_on[i]) free_held = i;
          end
          if (!seen && free_held >= 0) begin
            held_code[free_held] = it.key_code;
            held_on[free_held] = 1'b1;
          end
          for (int i = 0; i < SLOTS; i++) begin
            if (!press_on[i]) begin
              press_code[i] = it.key_code;
              press_on[i] = 1'b1;
              break;
            end
          end
        end
        OP_KEY_UP: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (held_on[i] && held_code[i] == it.key_code) begin
              held_on[i] = 1'b0;
              break;
            end
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < SLOTS; i++) press_on[i] = 1'b0;
        end
        default: ;
      endcase
      flags = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (held_on[i] && held_code[i] == it.key_code) flags.key_held = 1'b1;
        if (press_on[i] && press_code[i] == it.key_code) flags.key_pressed = 1'b1;
        if (held_on[i]) flags.any_held = 1'b1;
        if (press_on[i]) flags.any_pressed = 1'b1;
      end
      flags_due.push_back(flags);
    endfunction

    function void check_result(krt_result_t got);
      krt_result_t want;
      if (flags_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result %b with no item outstanding", $time, got);
        return;
      end
      want = flags_due.pop_front();
      if (got.key_held !== want.key_held || got.key_pressed !== want.key_pressed ||
          got.any_held !== want.any_held || got.any_pressed !== want.any_pressed) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch held %b/%b pressed %b/%b any_held %b/%b any_pressed %b/%b",
                   $time, want.key_held, got.key_held, want.key_pressed, got.key_pressed,
                   want.any_held, got.any_held, want.any_pressed, got.any_pressed);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  krt_item_t   item_i = '0;
  logic        done_o;
  krt_result_t result_o;

  rollover_scoreboard sb;
  logic [KEY_W-1:0] key_pool[10];

  key_rollover_tracker #(.SLOTS(SLOTS)) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(result_o);
  end

  // called at a rising edge; returns at the edge that accepts the item
  task automatic send_item(krt_op_e op, logic [KEY_W-1:0] key, bit quiet);
    krt_item_t it;
    it.operation = op;
    it.key_code = key;
    if (!quiet && $urandom_range(99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    sb.note_item(it);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    logic [31:0] r;
    int unsigned sel;
    sel = $urandom_range(99);
    r = $urandom;
    if (sel < 70) return key_pool[$urandom_range(9)];
    if (sel < 75) return KEY_ZERO;
    if (sel < 80) return KEY_TOP;
    return r[KEY_W-1:0];
  endfunction

  function automatic krt_op_e pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return OP_KEY_DOWN;
    if (r < 70) return OP_KEY_UP;
    if (r < 78) return OP_CLEAR;
    return OP_QUERY;
  endfunction

  initial begin
    logic [31:0] r;
    sb = new();
    for (int i = 0; i < 10; i++) begin
      r = $urandom;
      key_pool[i] = (i < 5) ? KEY_W'($urandom_range(15)) : r[KEY_W-1:0];
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty tables, extreme codes, repeat key-down, key-up of an absent key
    send_item(OP_QUERY, KEY_ZERO, 1'b0);
    send_item(OP_KEY_DOWN, KEY_TOP, 1'b0);
    send_item(OP_KEY_DOWN, KEY_ZERO, 1'b0);
    send_item(OP_KEY_DOWN, KEY_TOP, 1'b0);
    send_item(OP_KEY_UP, KEY_W'(5), 1'b0);
    send_item(OP_QUERY, KEY_ZERO, 1'b0);
    send_item(OP_CLEAR, KEY_ZERO, 1'b0);
    // fill the held table, then the press list, then overflow both
    for (int k = 1; k <= 9; k++) send_item(OP_KEY_DOWN, KEY_W'(k), 1'b0);
    send_item(OP_KEY_UP, KEY_ZERO, 1'b0);
    send_item(OP_KEY_UP, KEY_ZERO, 1'b0);
    send_item(OP_QUERY, KEY_TOP, 1'b0);
    send_item(OP_CLEAR, KEY_TOP, 1'b0);
    send_item(OP_QUERY, KEY_W'(8), 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150 || n == 350) begin
        start <= 1'b0;
        while (sb.flags_due.size() != 0) @(posedge clk_i);
      end
      send_item(pick_op(), pick_key(), n >= 150 && n < 300);
    end
    start <= 1'b0;

    while (sb.flags_due.size() != 0) @(posedge clk_i);
    repeat (2 * ITEM_LAT) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.flags_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
